[src/allc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allc_pkg
// Shared types, constants and the resolution table of the lux converter.
// ----------------------------------------------------------------------------
package allc_pkg;

   // field widths
   localparam int RAW_W   = 16;
   localparam int LUX_W   = 35;
   localparam int GAIN_W  = 2;
   localparam int INTEG_W = 3;
   localparam int RES_W   = 23;

   // output format
   localparam int FRAC_BITS = 8;
   localparam int LUX_SHIFT = 36 - FRAC_BITS;

   // pipeline depth, five working stages and the output register
   localparam int ALLC_DEPTH = 6;

   // csr register indexes (paddr[2])
   localparam logic REG_GAIN  = 1'b0;
   localparam logic REG_INTEG = 1'b1;

   // gain codes
   localparam logic [GAIN_W-1:0] GAIN_1X    = 2'd0;
   localparam logic [GAIN_W-1:0] GAIN_2X    = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_QTR   = 2'd2;
   localparam logic [GAIN_W-1:0] GAIN_EIGHT = 2'd3;

   // integration time codes
   localparam logic [INTEG_W-1:0] INTEG_25MS  = 3'd0;
   localparam logic [INTEG_W-1:0] INTEG_100MS = 3'd2;
   localparam logic [INTEG_W-1:0] INTEG_800MS = 3'd5;

   // correction coefficients
   localparam logic [19:0] COEF3_Q60 = 20'd693309;
   localparam logic [21:0] COEF2_Q48 = 22'd2643726;
   localparam logic [63:0] COEF1_CALC =
      ((64'd81488 << 32) + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] COEF0_CALC = ((64'd10023 << 20) + 64'd5000) / 64'd10000;
   localparam logic [18:0] COEF1_Q32 = COEF1_CALC[18:0];
   localparam logic [20:0] COEF0_Q20 = COEF0_CALC[20:0];

   // lux per count in Q1.22, rows by gain, columns by integration time
   localparam logic [RES_W-1:0] RES_TABLE [4][6] = '{
      '{23'd966368,  23'd483184,  23'd241592,  23'd120796, 23'd60398,  23'd30199},
      '{23'd483184,  23'd241592,  23'd120796,  23'd60398,  23'd30199,  23'd15099},
      '{23'd3865471, 23'd1932735, 23'd966368,  23'd483184, 23'd241592, 23'd120796},
      '{23'd7730941, 23'd3865471, 23'd1932735, 23'd966368, 23'd483184, 23'd241592}
   };

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_select;
      logic [INTEG_W-1:0] integration_select;
   } allc_cfg_type;

   // unused integration codes fall back to 100 ms
   function automatic logic [RES_W-1:0] res_lookup(input logic [GAIN_W-1:0] g,
                                                   input logic [INTEG_W-1:0] it);
      logic [INTEG_W-1:0] itc;
      itc = (it > INTEG_800MS) ? INTEG_100MS : it;
      return RES_TABLE[g][itc];
   endfunction

endpackage

[src/allc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allc_if
// Valid/ready channels for raw counts in and lux values out.
// ----------------------------------------------------------------------------
interface allc_req_if;
   logic                        valid;
   logic                        ready;
   logic [allc_pkg::RAW_W-1:0]  raw_count;

   modport source (output valid, output raw_count, input ready);
   modport sink   (input valid, input raw_count, output ready);
endinterface

interface allc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [allc_pkg::LUX_W-1:0]  lux_value;

   modport source (output valid, output lux_value, input ready);
   modport sink   (input valid, input lux_value, output ready);
endinterface

[src/allc_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allc_pipe
// Six-stage scaling and Horner correction datapath with elastic stalls.
// ----------------------------------------------------------------------------
module allc_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  allc_pkg::allc_cfg_type cfg,
   allc_req_if.sink               req,
   allc_rsp_if.source             rsp
);

   localparam int P0_W = allc_pkg::RES_W + allc_pkg::RAW_W;
   localparam int X_W  = 33;
   localparam int P1_W = 53;
   localparam int T_W  = 25;
   localparam int P2_W = T_W + X_W;
   localparam int B_W  = 26;
   localparam int P3_W = B_W + X_W;
   localparam int C_W  = 31;
   localparam int P4_W = 64;

   localparam logic [P0_W:0] X_HALF = (P0_W+1)'(1) << 5;
   localparam logic [P1_W:0] T_HALF = (P1_W+1)'(1) << 27;
   localparam logic [P2_W:0] Q_HALF = (P2_W+1)'(1) << 31;
   localparam logic [P3_W:0] R_HALF = (P3_W+1)'(1) << 27;
   localparam logic [P4_W:0] L_HALF = (P4_W+1)'(1) << (allc_pkg::LUX_SHIFT - 1);

   // stage registers
   logic                        s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, out_v_ff;
   logic [P0_W-1:0]             s1_p0_ff;
   logic [X_W-1:0]              s2_x_ff, s3_x_ff, s4_x_ff;
   logic [P1_W-1:0]             s2_p1_ff;
   logic [P2_W-1:0]             s3_p2_ff;
   logic                        s3_neg_ff;
   logic [P3_W-1:0]             s4_p3_ff;
   logic [P4_W-1:0]             s5_p4_ff;
   logic [allc_pkg::LUX_W-1:0]  out_lux_ff;

   // next values
   logic [P0_W-1:0]             s1_p0_in;
   logic [X_W-1:0]              s2_x_in;
   logic [P1_W-1:0]             s2_p1_in;
   logic [P2_W-1:0]             s3_p2_in;
   logic                        s3_neg_in;
   logic [P3_W-1:0]             s4_p3_in;
   logic [P4_W-1:0]             s5_p4_in;
   logic [allc_pkg::LUX_W-1:0]  out_lux_in;

   logic s1_en, s2_en, s3_en, s4_en, s5_en, out_en;

   // intermediates
   logic [P0_W:0]               x_sum;
   logic [P1_W:0]               t_sum;
   logic [T_W-1:0]              t_val;
   logic [T_W-1:0]              a_mag;
   logic [P2_W:0]               q_sum;
   logic [B_W-1:0]              q_val;
   logic [B_W-1:0]              b_val;
   logic [P3_W:0]               r_sum;
   logic [C_W-1:0]              c_val;
   logic [P4_W:0]               l_sum;
   logic [P4_W:0]               l_shift;

   // a stage takes a new beat when empty or when its contents move on
   assign out_en = !out_v_ff || rsp.ready;
   assign s5_en  = !s5_v_ff  || out_en;
   assign s4_en  = !s4_v_ff  || s5_en;
   assign s3_en  = !s3_v_ff  || s4_en;
   assign s2_en  = !s2_v_ff  || s3_en;
   assign s1_en  = !s1_v_ff  || s2_en;

   assign req.ready     = s1_en;
   assign rsp.valid     = out_v_ff;
   assign rsp.lux_value = out_lux_ff;

   always_comb begin
      // scale by resolution
      s1_p0_in = P0_W'(allc_pkg::res_lookup(cfg.gain_select, cfg.integration_select))
               * P0_W'(req.raw_count);

      // x in Q.16, then cubic term
      x_sum    = {1'b0, s1_p0_ff} + X_HALF;
      s2_x_in  = x_sum[6 +: X_W];
      s2_p1_in = P1_W'(allc_pkg::COEF3_Q60) * P1_W'(s2_x_in);

      // t - c2 as sign and magnitude
      t_sum     = {1'b0, s2_p1_ff} + T_HALF;
      t_val     = t_sum[28 +: T_W];
      s3_neg_in = t_val < T_W'(allc_pkg::COEF2_Q48);
      a_mag     = s3_neg_in ? (T_W'(allc_pkg::COEF2_Q48) - t_val)
                            : (t_val - T_W'(allc_pkg::COEF2_Q48));
      s3_p2_in  = P2_W'(a_mag) * P2_W'(s2_x_ff);

      // linear coefficient, clamped at zero
      q_sum = {1'b0, s3_p2_ff} + Q_HALF;
      q_val = q_sum[32 +: B_W];
      if (!s3_neg_ff) begin
         b_val = B_W'(allc_pkg::COEF1_Q32) + q_val;
      end else if (B_W'(allc_pkg::COEF1_Q32) >= q_val) begin
         b_val = B_W'(allc_pkg::COEF1_Q32) - q_val;
      end else begin
         b_val = '0;
      end
      s4_p3_in = P3_W'(b_val) * P3_W'(s3_x_ff);

      // constant coefficient
      r_sum    = {1'b0, s4_p3_ff} + R_HALF;
      c_val    = C_W'(allc_pkg::COEF0_Q20) + r_sum[28 +: C_W];
      s5_p4_in = P4_W'(c_val) * P4_W'(s4_x_ff);

      // final rounding and saturation
      l_sum   = {1'b0, s5_p4_ff} + L_HALF;
      l_shift = l_sum >> allc_pkg::LUX_SHIFT;
      if (|l_shift[P4_W:allc_pkg::LUX_W]) begin
         out_lux_in = '1;
      end else begin
         out_lux_in = l_shift[allc_pkg::LUX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_v_ff  <= req.valid;
         if (s2_en)  s2_v_ff  <= s1_v_ff;
         if (s3_en)  s3_v_ff  <= s2_v_ff;
         if (s4_en)  s4_v_ff  <= s3_v_ff;
         if (s5_en)  s5_v_ff  <= s4_v_ff;
         if (out_en) out_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_p0_ff <= s1_p0_in;
      end
      if (s2_en) begin
         s2_x_ff  <= s2_x_in;
         s2_p1_ff <= s2_p1_in;
      end
      if (s3_en) begin
         s3_x_ff   <= s2_x_ff;
         s3_p2_ff  <= s3_p2_in;
         s3_neg_ff <= s3_neg_in;
      end
      if (s4_en) begin
         s4_x_ff  <= s3_x_ff;
         s4_p3_ff <= s4_p3_in;
      end
      if (s5_en) begin
         s5_p4_ff <= s5_p4_in;
      end
      if (out_en) begin
         out_lux_ff <= out_lux_in;
      end
   end

endmodule

[src/ambient_light_lux_converter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_lux_converter_unit
// Raw light count to corrected lux, with gain and integration time set by csr.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req       in         valid / ready        raw_count  [15:0]
//  rsp       out        valid / ready        lux_value  [34:0]
//  csr       in         apb write/read       gain_select @0x0, integration_select @0x4
//
// one beat enters per cycle while req.ready is high; rsp valid rises once its
// beat has passed six register stages (five multiplier stages plus the output
// register), the first of which loads on the edge that takes the req beat
// reset is synchronous and active high; it empties the pipeline and loads
// gain 1/8 and 100 ms
// a stalled output holds its beat; stages behind it keep filling bubbles,
// so req.ready drops only once every stage holds a beat
//
module ambient_light_lux_converter_unit (
   input  logic        clock,
   input  logic        reset,
   allc_req_if.sink    req,
   allc_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration registers
   allc_pkg::allc_cfg_type cfg_ff;
   allc_pkg::allc_cfg_type cfg_in;

   logic csr_write;
   logic csr_index;

   // register select is paddr[2]; the low bits are ignored
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            allc_pkg::REG_GAIN: begin
               cfg_in.gain_select = pwdata[allc_pkg::GAIN_W-1:0];
            end
            allc_pkg::REG_INTEG: begin
               cfg_in.integration_select = pwdata[allc_pkg::INTEG_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_select        <= allc_pkg::GAIN_EIGHT;
         cfg_ff.integration_select <= allc_pkg::INTEG_100MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         allc_pkg::REG_GAIN:  prdata = 32'(cfg_ff.gain_select);
         allc_pkg::REG_INTEG: prdata = 32'(cfg_ff.integration_select);
         default:             prdata = '0;
      endcase
   end

   // scaling and cubic correction datapath
   allc_pipe u_pipe (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

[src/allc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module allc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [allc_pkg::LUX_W-1:0]  rsp_lux_value
);

   localparam int CNT_W = $clog2(allc_pkg::ALLC_DEPTH + 1);

   // beats taken but not yet delivered
   logic [CNT_W-1:0] pending_ff;
   logic [CNT_W-1:0] pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + CNT_W'(1);
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pending_in = pending_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_lux_value))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("rsp beat without a matching req beat");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(allc_pkg::ALLC_DEPTH))
      else $error("more beats in flight than pipeline stages");

endmodule

bind ambient_light_lux_converter_unit allc_checker u_allc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_lux_value (rsp.lux_value)
);

[dv/ambient_light_lux_converter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_lux_converter_unit_tb
// Feeds raw light counts through the converter under a range of gain and
// integration settings, predicts each corrected lux value in fixed point
// and compares it with the beat that comes out, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module ambient_light_lux_converter_unit_tb;

   typedef logic [allc_pkg::RAW_W-1:0]   raw_type;
   typedef logic [allc_pkg::LUX_W-1:0]   lux_type;
   typedef logic [allc_pkg::GAIN_W-1:0]  gain_type;
   typedef logic [allc_pkg::INTEG_W-1:0] integ_type;

   // integration codes that the package leaves unnamed
   localparam integ_type INTEG_50MS  = 3'd1;
   localparam integ_type INTEG_200MS = 3'd3;
   localparam integ_type INTEG_400MS = 3'd4;
   localparam integ_type INTEG_RSVD6 = 3'd6;
   localparam integ_type INTEG_RSVD7 = 3'd7;

   // correction coefficients, rebuilt here from their decimal values
   localparam logic [63:0] K3_Q60 = 64'd693309;
   localparam logic [63:0] K2_Q48 = 64'd2643726;
   localparam logic [63:0] K1_Q32 = ((64'd81488 << 32) + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] K0_Q20 = ((64'd10023 << 20) + 64'd5000) / 64'd10000;
   localparam logic [63:0] LUX_FULL = (64'd1 << allc_pkg::LUX_W) - 64'd1;

   // idle cycles with work outstanding before the run is declared hung
   localparam int unsigned STALL_LIMIT = 5000;

   // lux per count in Q1.22, six integration times per gain row
   localparam logic [22:0] LUX_PER_COUNT [24] = '{
      23'd966368,  23'd483184,  23'd241592,  23'd120796, 23'd60398,  23'd30199,
      23'd483184,  23'd241592,  23'd120796,  23'd60398,  23'd30199,  23'd15099,
      23'd3865471, 23'd1932735, 23'd966368,  23'd483184, 23'd241592, 23'd120796,
      23'd7730941, 23'd3865471, 23'd1932735, 23'd966368, 23'd483184, 23'd241592
   };

   typedef struct packed {
      raw_type raw;
      lux_type lux;
   } lux_exp_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   allc_req_if req_if ();
   allc_rsp_if rsp_if ();

   ambient_light_lux_converter_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // counts still to be offered, and lux values still owed by the block
   raw_type     raw_pending [$];
   lux_exp_type lux_owed [$];

   // testbench copy of the two settings, changed only with the pipe empty
   gain_type  cur_gain;
   integ_type cur_integ;

   int unsigned mismatches;
   int unsigned req_gap, req_calm, rsp_stall, rsp_calm, idle_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // round to nearest: add half an lsb, then shift
   function automatic logic [63:0] round_down(input logic [63:0] v, input int unsigned s);
      if (s == 0) return v;
      return (v + (64'd1 << (s - 1))) >> s;
   endfunction

   // scale the count, then Horner cubic correction in fixed point
   function automatic lux_type lux_from_count(input raw_type raw,
                                              input gain_type g,
                                              input integ_type it);
      integ_type itc;
      logic [63:0] x, t, d, b, c, lux;
      // unused codes act as 100 ms
      itc = (it > allc_pkg::INTEG_800MS) ? allc_pkg::INTEG_100MS : it;
      x   = round_down(64'(LUX_PER_COUNT[g * 6 + itc]) * 64'(raw), 6);
      t   = round_down(K3_Q60 * x, 28);
      if (t >= K2_Q48) begin
         b = K1_Q32 + round_down((t - K2_Q48) * x, 32);
      end else begin
         // negative middle term, clamped at zero
         d = round_down((K2_Q48 - t) * x, 32);
         b = (K1_Q32 >= d) ? (K1_Q32 - d) : 64'd0;
      end
      c   = K0_Q20 + round_down(b * x, 28);
      lux = round_down(c * x, allc_pkg::LUX_SHIFT);
      if (lux > LUX_FULL) lux = LUX_FULL;   // saturate at full scale
      return lux[allc_pkg::LUX_W-1:0];
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // mix of full range, small and near-top counts
   function automatic raw_type pick_count();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return raw_type'($urandom_range(0, 65535));
      if (r < 8) return raw_type'($urandom_range(0, 255));
      return raw_type'($urandom_range(65000, 65535));
   endfunction

   task automatic queue_random(input int unsigned n);
      repeat (n) raw_pending.push_back(pick_count());
   endtask

   // apb write with setup and access phases; upper bits sometimes carry junk the block must drop
   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      logic [31:0] wdata, keep;
      keep  = (reg_idx == allc_pkg::REG_GAIN) ? 32'h3 : 32'h7;
      wdata = (value & keep) | ((($urandom_range(0, 3) == 0) ? $urandom() : 32'h0) & ~keep);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (reg_idx == allc_pkg::REG_GAIN) cur_gain = value[allc_pkg::GAIN_W-1:0];
      else cur_integ = value[allc_pkg::INTEG_W-1:0];
   endtask

   // sender holds off until every owed result is back and the pipe has drained
   task automatic wait_drained();
      while (raw_pending.size() != 0 || lux_owed.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (allc_pkg::ALLC_DEPTH + 2) @(posedge clock);
   endtask

   // request driver: one count per beat, holds while the block stalls
   always @(posedge clock) begin
      logic    nvalid;
      raw_type nraw;
      nvalid = req_if.valid;
      nraw   = req_if.raw_count;
      if (reset) begin
         nvalid = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            lux_owed.push_back('{raw: req_if.raw_count,
                                 lux: lux_from_count(req_if.raw_count, cur_gain, cur_integ)});
            nvalid  = 1'b0;
            req_gap = (req_calm != 0) ? 0 : pick_gap();
            // occasional stretch of back-to-back beats
            if (req_calm != 0) req_calm--;
            else if ($urandom_range(0, 99) == 0) req_calm = $urandom_range(40, 160);
         end
         if (!nvalid) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (raw_pending.size() != 0) begin
               nvalid = 1'b1;
               nraw   = raw_pending.pop_front();
            end
         end
      end
      req_if.valid     <= nvalid;
      req_if.raw_count <= nraw;
   end

   // result monitor: check each beat against the oldest owed value
   always @(posedge clock) begin
      lux_exp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (lux_owed.size() == 0) begin
               if (mismatches < 10)
                  $display("lux beat with none owed: got %0d", rsp_if.lux_value);
               mismatches++;
            end else begin
               want = lux_owed.pop_front();
               if (rsp_if.lux_value !== want.lux) begin
                  if (mismatches < 10)
                     $display("lux mismatch for raw %0d: expected %0d got %0d",
                              want.raw, want.lux, rsp_if.lux_value);
                  mismatches++;
               end
            end
            rsp_stall = (rsp_calm != 0) ? 0 : pick_gap();
            if (rsp_calm != 0) rsp_calm--;
            else if ($urandom_range(0, 99) == 0) rsp_calm = $urandom_range(40, 160);
         end else if (rsp_stall == 0 && rsp_calm == 0 && $urandom_range(0, 15) == 0) begin
            rsp_stall = pick_gap();
         end
         rsp_if.ready <= (rsp_stall == 0);
         if (rsp_stall != 0) rsp_stall--;
      end
   end

   // watchdog: only counts while work is outstanding
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else if (raw_pending.size() != 0 || lux_owed.size() != 0 || req_if.valid) begin
         idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      gain_type  set_gain  [8];
      integ_type set_integ [8];
      clock            = 1'b1;
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_if.valid     = 1'b0;
      req_if.raw_count = '0;
      rsp_if.ready     = 1'b0;
      mismatches       = 0;
      req_gap          = 0;
      req_calm         = 0;
      rsp_stall        = 0;
      rsp_calm         = 0;
      idle_cycles      = 0;
      cur_gain         = allc_pkg::GAIN_EIGHT;
      cur_integ        = allc_pkg::INTEG_100MS;

      // fixed settings: corners of the table, both unused integration codes, 200 ms and 400 ms
      set_gain  = '{allc_pkg::GAIN_1X, allc_pkg::GAIN_EIGHT,
                    allc_pkg::GAIN_1X, allc_pkg::GAIN_EIGHT,
                    allc_pkg::GAIN_2X, allc_pkg::GAIN_QTR,
                    allc_pkg::GAIN_2X, allc_pkg::GAIN_QTR};
      set_integ = '{allc_pkg::INTEG_25MS, allc_pkg::INTEG_800MS,
                    allc_pkg::INTEG_800MS, allc_pkg::INTEG_25MS,
                    INTEG_RSVD6, INTEG_RSVD7, INTEG_200MS, INTEG_400MS};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset setting first: count extremes and alternating bit patterns
      raw_pending = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF,
                      16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA};
      queue_random(40);
      wait_drained();

      foreach (set_gain[i]) begin
         csr_write(allc_pkg::REG_GAIN, 32'(set_gain[i]));
         csr_write(allc_pkg::REG_INTEG, 32'(set_integ[i]));
         raw_pending.push_back(16'hFFFF);
         raw_pending.push_back(16'h0001);
         queue_random(40);
         wait_drained();
      end

      // random settings, some with 50 ms, the rest drawn over every code
      repeat (12) begin
         csr_write(allc_pkg::REG_GAIN, 32'($urandom_range(0, 3)));
         csr_write(allc_pkg::REG_INTEG, ($urandom_range(0, 3) == 0) ? 32'(INTEG_50MS)
                                                                    : 32'($urandom_range(0, 7)));
         queue_random(75);
         wait_drained();
      end

      repeat (4 * allc_pkg::ALLC_DEPTH) @(posedge clock);
      if (mismatches == 0 && lux_owed.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[ambient_light_lux_converter_unit.f]
src/allc_pkg.sv
src/allc_if.sv
src/allc_pipe.sv
src/ambient_light_lux_converter_unit.sv
src/allc_checker.sv
dv/ambient_light_lux_converter_unit_tb.sv
